// File: hdl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared constants, command type and ring slot helpers for the stereo
// loopback ring.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int RING_FRAMES     = 65536;
    localparam int MAX_READ_FRAMES = 64;
    localparam int RING_AW         = $clog2(RING_FRAMES);
    localparam int SAMPLE_W        = 32;
    localparam int FRAME_W         = 2 * SAMPLE_W;
    localparam int TOTAL_W         = 64;
    localparam int CNT_W           = 7;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_kind_t;

    typedef logic [RING_AW-1:0] slot_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed
    {
        cmd_kind_t            kind;
        slot_t                slot;
        logic [FRAME_W-1:0]   frame;
        cnt_t                 silence;
        cnt_t                 copy;
    } cmd_t;

    // slot + n modulo RING_FRAMES, n never above RING_FRAMES
    function automatic slot_t slot_add(input slot_t s, input cnt_t n);
        logic [RING_AW:0] sum;
        begin
            sum = {1'b0, s} + (RING_AW + 1)'(n);
            if (sum >= (RING_AW + 1)'(RING_FRAMES))
            begin
                sum = sum - (RING_AW + 1)'(RING_FRAMES);
            end
            slot_add = sum[RING_AW-1:0];
        end
    endfunction

    // slot - n modulo RING_FRAMES
    function automatic slot_t slot_sub(input slot_t s, input cnt_t n);
        logic [RING_AW:0] dif;
        begin
            if ({1'b0, s} >= (RING_AW + 1)'(n))
            begin
                dif = {1'b0, s} - (RING_AW + 1)'(n);
            end
            else
            begin
                dif = {1'b0, s} + (RING_AW + 1)'(RING_FRAMES) - (RING_AW + 1)'(n);
            end
            slot_sub = dif[RING_AW-1:0];
        end
    endfunction

endpackage

// File: hdl/slr_ram.sv
// ----------------------------------------------------------------------------
// slr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module slr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/slr_front.sv
// ----------------------------------------------------------------------------
// slr_front
// Request front end: keeps the write and read totals, resolves the reader
// jump and splits each read block into silence and copy counts.
// ----------------------------------------------------------------------------
module slr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           kind,
    input  logic [slr_pkg::SAMPLE_W-1:0]   left_in,
    input  logic [slr_pkg::SAMPLE_W-1:0]   right_in,
    input  logic [slr_pkg::CNT_W-1:0]      frame_count,
    input  logic                           fifo_full,
    output logic                           push,
    output slr_pkg::cmd_t                  cmd
);

    import slr_pkg::*;

    logic [TOTAL_W-1:0] wr_total_reg, wr_total_next;
    logic [TOTAL_W-1:0] rd_total_reg, rd_total_next;
    slot_t              wr_slot_reg, wr_slot_next;
    slot_t              rd_slot_reg, rd_slot_next;

    logic               accept;
    logic               is_read;
    cnt_t               want;
    logic               ahead;
    logic [TOTAL_W-1:0] diff;
    logic               jump;
    cnt_t               copy;

    assign req_ready = !fifo_full;
    assign accept    = req_valid && !fifo_full;
    assign is_read   = (cmd_kind_t'(kind) == CMD_READ);

    always_comb
    begin
        want = (frame_count > CNT_W'(MAX_READ_FRAMES)) ? CNT_W'(MAX_READ_FRAMES) : frame_count;
        ahead = (wr_total_reg > rd_total_reg);
        diff  = wr_total_reg - rd_total_reg;
        jump  = ahead && (diff > TOTAL_W'(RING_FRAMES));

        // after a jump exactly want frames sit between reader and writer
        if (jump || (ahead && (diff >= TOTAL_W'(want))))
        begin
            copy = want;
        end
        else if (ahead)
        begin
            copy = diff[CNT_W-1:0];
        end
        else
        begin
            copy = '0;
        end

        cmd.kind    = is_read ? CMD_READ : CMD_WRITE;
        cmd.frame   = {right_in, left_in};
        cmd.silence = want - copy;
        cmd.copy    = copy;
        if (is_read)
        begin
            cmd.slot = jump ? slot_sub(wr_slot_reg, want) : rd_slot_reg;
        end
        else
        begin
            cmd.slot = wr_slot_reg;
        end

        // an empty read block only moves the reader
        push = accept && (!is_read || (want != '0));

        wr_total_next = wr_total_reg;
        wr_slot_next  = wr_slot_reg;
        rd_total_next = rd_total_reg;
        rd_slot_next  = rd_slot_reg;
        if (accept)
        begin
            if (!is_read)
            begin
                wr_total_next = wr_total_reg + TOTAL_W'(1);
                wr_slot_next  = slot_add(wr_slot_reg, CNT_W'(1));
            end
            else if (jump)
            begin
                rd_total_next = wr_total_reg;
                rd_slot_next  = wr_slot_reg;
            end
            else
            begin
                rd_total_next = rd_total_reg + TOTAL_W'(copy);
                rd_slot_next  = slot_add(rd_slot_reg, copy);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_total_reg <= '0;
            rd_total_reg <= '0;
            wr_slot_reg  <= '0;
            rd_slot_reg  <= '0;
        end
        else
        begin
            wr_total_reg <= wr_total_next;
            rd_total_reg <= rd_total_next;
            wr_slot_reg  <= wr_slot_next;
            rd_slot_reg  <= rd_slot_next;
        end
    end

endmodule

// File: hdl/slr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// slr_cmd_fifo
// Short command queue between the front end and the ring engine.
// ----------------------------------------------------------------------------
module slr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  slr_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output slr_pkg::cmd_t cmd_out,
    output logic          empty
);

    import slr_pkg::*;

    cmd_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full    = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/slr_back.sv
// ----------------------------------------------------------------------------
// slr_back
// Ring engine: writes frames into the ring memory and plays read blocks
// out as silence beats followed by frames fetched from the ring.
// ----------------------------------------------------------------------------
module slr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fifo_empty,
    input  slr_pkg::cmd_t                 cmd,
    output logic                          pop,
    output logic                          ram_en,
    output logic                          ram_we,
    output slr_pkg::slot_t                ram_addr,
    output logic [slr_pkg::FRAME_W-1:0]   ram_wdata,
    input  logic [slr_pkg::FRAME_W-1:0]   ram_rdata,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [slr_pkg::SAMPLE_W-1:0]  left_out,
    output logic [slr_pkg::SAMPLE_W-1:0]  right_out,
    output logic                          is_silence,
    output logic                          last
);

    import slr_pkg::*;

    logic               cur_valid_reg, cur_valid_next;
    cmd_kind_t          cur_kind_reg, cur_kind_next;
    slot_t              cur_slot_reg, cur_slot_next;
    logic [FRAME_W-1:0] cur_frame_reg, cur_frame_next;
    cnt_t               sil_left_reg, sil_left_next;
    cnt_t               copy_left_reg, copy_left_next;

    logic               pend_reg, pend_next;
    logic               pend_last_reg, pend_last_next;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] left_reg, left_next;
    logic [SAMPLE_W-1:0] right_reg, right_next;
    logic                sil_reg, sil_next;
    logic                last_reg, last_next;

    logic out_free;
    logic load_data;
    logic do_write;
    logic do_sil;
    logic do_issue;
    logic cur_done;
    logic is_rd;

    always_comb
    begin
        out_free  = !out_valid_reg || rsp_ready;
        load_data = pend_reg && out_free;
        is_rd     = cur_valid_reg && (cur_kind_reg == CMD_READ);
        do_write  = cur_valid_reg && (cur_kind_reg == CMD_WRITE);
        do_sil    = is_rd && (sil_left_reg != '0) && !pend_reg && out_free;
        do_issue  = is_rd && (sil_left_reg == '0) && (copy_left_reg != '0)
                    && (!pend_reg || out_free);
        cur_done  = do_write
                    || (do_sil && (sil_left_reg == CNT_W'(1)) && (copy_left_reg == '0))
                    || (do_issue && (copy_left_reg == CNT_W'(1)));
        pop       = !fifo_empty && (!cur_valid_reg || cur_done);

        ram_en    = do_write || do_issue;
        ram_we    = do_write;
        ram_addr  = cur_slot_reg;
        ram_wdata = cur_frame_reg;

        // advance the current command
        cur_valid_next = cur_valid_reg && !cur_done;
        cur_kind_next  = cur_kind_reg;
        cur_slot_next  = cur_slot_reg;
        cur_frame_next = cur_frame_reg;
        sil_left_next  = sil_left_reg;
        copy_left_next = copy_left_reg;
        if (do_sil)
        begin
            sil_left_next = sil_left_reg - 1'b1;
        end
        if (do_issue)
        begin
            copy_left_next = copy_left_reg - 1'b1;
            cur_slot_next  = slot_add(cur_slot_reg, CNT_W'(1));
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_kind_next  = cmd.kind;
            cur_slot_next  = cmd.slot;
            cur_frame_next = cmd.frame;
            sil_left_next  = cmd.silence;
            copy_left_next = cmd.copy;
        end

        // ring read in flight; ram data holds until it is taken
        pend_next      = do_issue ? 1'b1 : (load_data ? 1'b0 : pend_reg);
        pend_last_next = do_issue ? (copy_left_reg == CNT_W'(1)) : pend_last_reg;

        out_valid_next = (load_data || do_sil) ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);
        left_next      = left_reg;
        right_next     = right_reg;
        sil_next       = sil_reg;
        last_next      = last_reg;
        if (load_data)
        begin
            left_next  = ram_rdata[SAMPLE_W-1:0];
            right_next = ram_rdata[FRAME_W-1:SAMPLE_W];
            sil_next   = 1'b0;
            last_next  = pend_last_reg;
        end
        else if (do_sil)
        begin
            left_next  = '0;
            right_next = '0;
            sil_next   = 1'b1;
            last_next  = (sil_left_reg == CNT_W'(1)) && (copy_left_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_kind_reg  <= cur_kind_next;
        cur_slot_reg  <= cur_slot_next;
        cur_frame_reg <= cur_frame_next;
        sil_left_reg  <= sil_left_next;
        copy_left_reg <= copy_left_next;
        pend_last_reg <= pend_last_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        sil_reg       <= sil_next;
        last_reg      <= last_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign left_out   = left_reg;
    assign right_out  = right_reg;
    assign is_silence = sil_reg;
    assign last       = last_reg;

endmodule

// File: hdl/stereo_loopback_ring.sv
// ----------------------------------------------------------------------------
// stereo_loopback_ring
// Loopback ring for stereo frames with underrun padding on read blocks.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready): kind 0 writes one left/right frame
// into the ring, kind 1 asks for a block of frame_count frames (capped at 64).
// Response channel (rsp_valid/rsp_ready): one beat per frame of a read block,
// silence beats first for any shortfall, then ring frames oldest first; last
// marks the final beat. Write requests and empty read blocks give no beat.
// Requests pass through a four-entry command queue. Writes and read blocks
// share the single ring memory port; a running block fetches one beat per
// cycle from it while the receiver takes beats. A first beat passes the queue
// and the current command register, then the output register if padding, or
// the memory data register and output register if a ring frame. The front end
// accepts one request per cycle while the queue has room.
// Reset clears the write and read totals, the queue and the output stage; the
// ring contents are not cleared and need no clearing pass.
// When the receiver holds rsp_ready low the beat waits in the output register,
// one ring read stays parked in the memory data register, and further requests
// are taken until the queue fills.
// ----------------------------------------------------------------------------
module stereo_loopback_ring (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           kind,
    input  logic [slr_pkg::SAMPLE_W-1:0]   left_in,
    input  logic [slr_pkg::SAMPLE_W-1:0]   right_in,
    input  logic [slr_pkg::CNT_W-1:0]      frame_count,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [slr_pkg::SAMPLE_W-1:0]   left_out,
    output logic [slr_pkg::SAMPLE_W-1:0]   right_out,
    output logic                           is_silence,
    output logic                           last
);

    import slr_pkg::*;

    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    cmd_t               push_cmd;
    cmd_t               pop_cmd;
    logic               ram_en;
    logic               ram_we;
    slot_t              ram_addr;
    logic [FRAME_W-1:0] ram_wdata;
    logic [FRAME_W-1:0] ram_rdata;

    slr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .kind        (kind),
        .left_in     (left_in),
        .right_in    (right_in),
        .frame_count (frame_count),
        .fifo_full   (fifo_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    slr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .full    (fifo_full),
        .pop     (pop),
        .cmd_out (pop_cmd),
        .empty   (fifo_empty)
    );

    slr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (RING_FRAMES)
    ) u_ring (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    slr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .cmd        (pop_cmd),
        .pop        (pop),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .left_out   (left_out),
        .right_out  (right_out),
        .is_silence (is_silence),
        .last       (last)
    );

`ifndef SYNTHESIS
    // padding beats carry zero samples
    a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_silence) |-> (left_out == '0) && (right_out == '0))
        else $error("silence beat with nonzero samples");

    // a queued command is visible in the queue the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !fifo_empty)
        else $error("pushed command missing from queue");

    // within a block, silence never follows a ring frame
    a_silence_first: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !is_silence && !last) |=> !(rsp_valid && is_silence))
        else $error("silence beat after ring frame in one block");

    // the queue is never pushed when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("command queue overflow");
`endif

endmodule
